// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Each check is sampled on the rising edge of clk; CHK_CLK is off while rst_n is low, CHK_ALWAYS is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with reset qualification.
`define CHK_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also checks during reset.
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/baro_pkg.sv -----
// Package for the barometric compensation block: constants and the
// single-precision float helpers (round/pack, multiply, add, conversions).
package baro_pkg;

  localparam logic [7:0]  STATUS_PRESS_READY = 8'h20;
  localparam logic [7:0]  STATUS_TEMP_READY  = 8'h40;
  localparam logic [23:0] RAW_RESET_VALUE    = 24'h800000;
  localparam logic [31:0] FP_HUNDRED         = 32'h42C80000;
  localparam logic [31:0] FP_QNAN            = 32'h7FC00000;
  localparam logic [1:0]  CFG_IDX_LO         = 2'd0;
  localparam logic [1:0]  CFG_IDX_MID        = 2'd1;
  localparam logic [1:0]  CFG_IDX_HI         = 2'd2;

  // Normalizes and rounds (to nearest even) the value m * 2^x, with
  // subnormal and overflow handling.
  function automatic logic [31:0] fp_round(input logic s, input int x,
                                           input logic [51:0] m);
    int          lz;
    int          e;
    int          sh;
    logic [51:0] n;
    logic [51:0] n2;
    logic        lost;
    logic [23:0] mant;
    logic        guard;
    logic        sticky;
    logic        up;
    logic [24:0] r;
    lz = 0;
    lost = 1'b0;
    for (int i = 0; i < 52; i++) begin
      if (m[i]) lz = 51 - i;
    end
    if (m == '0) begin
      fp_round = {s, 31'b0};
    end else begin
      n = m << lz;
      e = x - lz + 178;
      if (e < 1) begin
        sh = 1 - e;
        if (sh > 52) sh = 52;
        n2 = n >> sh;
        lost = ((n2 << sh) != n);
        n = n2;
        e = 0;
      end
      mant = n[51:28];
      guard = n[27];
      sticky = (|n[26:0]) | lost;
      up = guard & (sticky | mant[0]);
      r = {1'b0, mant} + {24'b0, up};
      if (e == 0) begin
        fp_round = {s, 7'b0, r[23], r[22:0]};
      end else begin
        if (r[24]) begin
          r = r >> 1;
          e = e + 1;
        end
        if (e >= 255) fp_round = {s, 8'hFF, 23'b0};
        else fp_round = {s, e[7:0], r[22:0]};
      end
    end
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    int          ea;
    int          eb;
    s = a[31] ^ b[31];
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = (a[30:0] == '0);
    b_zero = (b[30:0] == '0);
    ma = {(a[30:23] != 8'h00), a[22:0]};
    mb = {(b[30:23] != 8'h00), b[22:0]};
    ea = (a[30:23] == 8'h00) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 8'h00) ? 1 : int'(b[30:23]);
    p = ma * mb;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) fp_mul = FP_QNAN;
    else if (a_inf || b_inf) fp_mul = {s, 8'hFF, 23'b0};
    else fp_mul = fp_round(s, ea + eb - 300, {4'b0, p});
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] sml;
    logic [51:0] mbig;
    logic [51:0] msml;
    logic [51:0] shifted;
    logic [51:0] sum;
    logic        lost;
    int          eb;
    int          es;
    int          d;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    if (a[30:0] >= b[30:0]) begin
      big = a;
      sml = b;
    end else begin
      big = b;
      sml = a;
    end
    eb = (big[30:23] == 8'h00) ? 1 : int'(big[30:23]);
    es = (sml[30:23] == 8'h00) ? 1 : int'(sml[30:23]);
    d = eb - es;
    if (d > 52) d = 52;
    mbig = {1'b0, (big[30:23] != 8'h00), big[22:0], 27'b0};
    msml = {1'b0, (sml[30:23] != 8'h00), sml[22:0], 27'b0};
    shifted = msml >> d;
    lost = ((shifted << d) != msml);
    shifted[0] = shifted[0] | lost;
    if (big[31] == sml[31]) sum = mbig + shifted;
    else sum = mbig - shifted;
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) fp_add = FP_QNAN;
    else if (a_inf) fp_add = a;
    else if (b_inf) fp_add = b;
    else if ((a[30:0] == '0) && (b[30:0] == '0)) fp_add = {a[31] & b[31], 31'b0};
    else if (sum == '0) fp_add = 32'h0;
    else fp_add = fp_round(big[31], eb - 177, sum);
  endfunction

  // Exact conversion of a small signed integer scaled by 2^x.
  function automatic logic [31:0] sint_to_fp(input logic signed [17:0] v, input int x);
    logic [17:0] mag;
    mag = v[17] ? 18'(-v) : 18'(v);
    sint_to_fp = fp_round(v[17], x, {34'b0, mag});
  endfunction

  // Truncation toward zero with saturation to int16; NaN gives zero.
  function automatic logic signed [15:0] fp_to_centi(input logic [31:0] f);
    logic [23:0] mag;
    int          e;
    e = int'(f[30:23]);
    mag = '0;
    if ((e == 255) && (f[22:0] != '0)) begin
      fp_to_centi = '0;
    end else if (e >= 142) begin
      fp_to_centi = f[31] ? 16'sh8000 : 16'sh7FFF;
    end else if (e < 127) begin
      fp_to_centi = '0;
    end else begin
      mag = {1'b1, f[22:0]} >> (150 - e);
      fp_to_centi = f[31] ? 16'(-mag[15:0]) : 16'(mag[15:0]);
    end
  endfunction

endpackage

// ----- rtl/baro_sensor_compensation.sv -----
// Barometric compensation top level; uses baro_pkg and assert_macros.svh.
// Single-precision temperature and cubic pressure polynomial, fully pipelined.
//
// A beat is taken at every clock edge where start is high; busy is always low
// because the pipeline never stalls. A sample whose status byte shows both
// pressure and temperature ready produces one result beat, marked by
// out_valid for one cycle, after it passes the twelve register stages of the
// float chain; other samples produce nothing. The stages are the input
// conversion, which loads at the accepting edge, one multiply or add per
// stage after it, and the output add. Up to twelve samples are in flight.
// Calibration registers are written through cfg_we, cfg_index and cfg_data
// and must stay unchanged while samples are in the pipeline.
`include "assert_macros.svh"

module baro_sensor_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [7:0]         in_status_byte,
  input  logic [23:0]        in_raw_pressure,
  input  logic [23:0]        in_raw_temperature,
  output logic               out_valid,
  output logic signed [15:0] out_temp_centi,
  output logic [31:0]        out_pressure_float,
  output logic               out_reset_value_seen,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [63:0] calib_lo_r, calib_mid_r;
  logic [39:0] calib_hi_r;
  logic [7:0]  cb [21];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_lo_r  <= '0;
      calib_mid_r <= '0;
      calib_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        baro_pkg::CFG_IDX_LO:  calib_lo_r  <= cfg_data;
        baro_pkg::CFG_IDX_MID: calib_mid_r <= cfg_data;
        baro_pkg::CFG_IDX_HI:  calib_hi_r  <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cb[k]     = calib_lo_r[8*k +: 8];
      cb[k + 8] = calib_mid_r[8*k +: 8];
    end
    for (int k = 0; k < 5; k++) begin
      cb[k + 16] = calib_hi_r[8*k +: 8];
    end
  end

  // Coefficients are exact conversions; registered once for timing.
  logic [31:0] t1_r, t2_r, t3_r, p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r;
  logic [31:0] p8_r, p9_r, p10_r, p11_r;

  always_ff @(posedge clk) begin
    t1_r  <= baro_pkg::sint_to_fp({2'b0, cb[1], cb[0]}, 8);
    t2_r  <= baro_pkg::sint_to_fp({2'b0, cb[3], cb[2]}, -30);
    t3_r  <= baro_pkg::sint_to_fp(18'(signed'(cb[4])), -48);
    p1_r  <= baro_pkg::sint_to_fp(18'(signed'({cb[6], cb[5]})) - 18'sd16384, -20);
    p2_r  <= baro_pkg::sint_to_fp(18'(signed'({cb[8], cb[7]})) - 18'sd16384, -29);
    p3_r  <= baro_pkg::sint_to_fp(18'(signed'(cb[9])), -32);
    p4_r  <= baro_pkg::sint_to_fp(18'(signed'(cb[10])), -37);
    p5_r  <= baro_pkg::sint_to_fp({2'b0, cb[12], cb[11]}, 3);
    p6_r  <= baro_pkg::sint_to_fp({2'b0, cb[14], cb[13]}, -6);
    p7_r  <= baro_pkg::sint_to_fp(18'(signed'(cb[15])), -8);
    p8_r  <= baro_pkg::sint_to_fp(18'(signed'(cb[16])), -15);
    p9_r  <= baro_pkg::sint_to_fp(18'(signed'({cb[18], cb[17]})), -48);
    p10_r <= baro_pkg::sint_to_fp(18'(signed'(cb[19])), -48);
    p11_r <= baro_pkg::sint_to_fp(18'(signed'(cb[20])), -65);
  end

  logic accept;
  logic ready_bits;
  assign busy = 1'b0;
  assign accept = start && !busy;
  assign ready_bits = ((in_status_byte & baro_pkg::STATUS_PRESS_READY) != '0) &&
                      ((in_status_byte & baro_pkg::STATUS_TEMP_READY) != '0);

  // Valid bits, one per stage.
  logic [11:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else v_r <= {v_r[10:0], accept && ready_bits};
  end

  // Stage 1: conversions.
  logic [31:0] s1_rt_r, s1_up_r;
  logic        s1_flag_r;
  // Stage 2 onward.
  logic [31:0] s2_d1_r, s2_up_r;
  logic        s2_flag_r;
  logic [31:0] s3_d2_r, s3_sq_r, s3_c1_r, s3_up_r;
  logic        s3_flag_r;
  logic [31:0] s4_d2_r, s4_sq_r, s4_c1_r, s4_cube_r, s4_up_r;
  logic        s4_flag_r;
  logic [31:0] s5_tl_r, s5_c1_r, s5_cube_r, s5_up_r;
  logic        s5_flag_r;
  logic [31:0] s6_centi_r, s6_tl2_r, s6_a1_r, s6_b1_r, s6_c2_r, s6_tl_r, s6_c1_r;
  logic [31:0] s6_cube_r, s6_up_r;
  logic        s6_flag_r;
  logic [31:0] s7_tl3_r, s7_a2_r, s7_b2_r, s7_out1_r, s7_bsum_r, s7_c2_r, s7_c1_r;
  logic [31:0] s7_cube_r, s7_up_r;
  logic signed [15:0] s7_centi_r;
  logic        s7_flag_r;
  logic [31:0] s8_a3_r, s8_b3_r, s8_out1_r, s8_bsum_r, s8_c3_r, s8_cube_r, s8_up_r;
  logic signed [15:0] s8_centi_r;
  logic        s8_flag_r;
  logic [31:0] s9_out1_r, s9_bsum_r, s9_c4_r, s9_up_r;
  logic signed [15:0] s9_centi_r;
  logic        s9_flag_r;
  logic [31:0] s10_out2_r, s10_out1_r, s10_c4_r;
  logic signed [15:0] s10_centi_r;
  logic        s10_flag_r;
  logic [31:0] s11_press_r, s11_c4_r;
  logic signed [15:0] s11_centi_r;
  logic        s11_flag_r;

  always_ff @(posedge clk) begin
    s1_rt_r   <= baro_pkg::fp_round(1'b0, 0, {28'b0, in_raw_temperature});
    s1_up_r   <= baro_pkg::fp_round(1'b0, 0, {28'b0, in_raw_pressure});
    s1_flag_r <= (in_raw_pressure == baro_pkg::RAW_RESET_VALUE) ||
                 (in_raw_temperature == baro_pkg::RAW_RESET_VALUE);

    s2_d1_r   <= baro_pkg::fp_add(s1_rt_r, {~t1_r[31], t1_r[30:0]});
    s2_up_r   <= s1_up_r;
    s2_flag_r <= s1_flag_r;

    s3_d2_r   <= baro_pkg::fp_mul(s2_d1_r, t2_r);
    s3_sq_r   <= baro_pkg::fp_mul(s2_d1_r, s2_d1_r);
    s3_c1_r   <= baro_pkg::fp_mul(s2_up_r, s2_up_r);
    s3_up_r   <= s2_up_r;
    s3_flag_r <= s2_flag_r;

    s4_d2_r   <= s3_d2_r;
    s4_sq_r   <= baro_pkg::fp_mul(s3_sq_r, t3_r);
    s4_c1_r   <= s3_c1_r;
    s4_cube_r <= baro_pkg::fp_mul(s3_c1_r, s3_up_r);
    s4_up_r   <= s3_up_r;
    s4_flag_r <= s3_flag_r;

    s5_tl_r   <= baro_pkg::fp_add(s4_d2_r, s4_sq_r);
    s5_c1_r   <= s4_c1_r;
    s5_cube_r <= baro_pkg::fp_mul(s4_cube_r, p11_r);
    s5_up_r   <= s4_up_r;
    s5_flag_r <= s4_flag_r;

    s6_centi_r <= baro_pkg::fp_mul(s5_tl_r, baro_pkg::FP_HUNDRED);
    s6_tl2_r   <= baro_pkg::fp_mul(s5_tl_r, s5_tl_r);
    s6_a1_r    <= baro_pkg::fp_mul(p6_r, s5_tl_r);
    s6_b1_r    <= baro_pkg::fp_mul(p2_r, s5_tl_r);
    s6_c2_r    <= baro_pkg::fp_mul(p10_r, s5_tl_r);
    s6_tl_r    <= s5_tl_r;
    s6_c1_r    <= s5_c1_r;
    s6_cube_r  <= s5_cube_r;
    s6_up_r    <= s5_up_r;
    s6_flag_r  <= s5_flag_r;

    s7_tl3_r   <= baro_pkg::fp_mul(s6_tl2_r, s6_tl_r);
    s7_a2_r    <= baro_pkg::fp_mul(p7_r, s6_tl2_r);
    s7_b2_r    <= baro_pkg::fp_mul(p3_r, s6_tl2_r);
    s7_out1_r  <= baro_pkg::fp_add(p5_r, s6_a1_r);
    s7_bsum_r  <= baro_pkg::fp_add(p1_r, s6_b1_r);
    s7_c2_r    <= baro_pkg::fp_add(p9_r, s6_c2_r);
    s7_centi_r <= baro_pkg::fp_to_centi(s6_centi_r);
    s7_c1_r    <= s6_c1_r;
    s7_cube_r  <= s6_cube_r;
    s7_up_r    <= s6_up_r;
    s7_flag_r  <= s6_flag_r;

    s8_a3_r    <= baro_pkg::fp_mul(p8_r, s7_tl3_r);
    s8_b3_r    <= baro_pkg::fp_mul(p4_r, s7_tl3_r);
    s8_out1_r  <= baro_pkg::fp_add(s7_out1_r, s7_a2_r);
    s8_bsum_r  <= baro_pkg::fp_add(s7_bsum_r, s7_b2_r);
    s8_c3_r    <= baro_pkg::fp_mul(s7_c1_r, s7_c2_r);
    s8_cube_r  <= s7_cube_r;
    s8_up_r    <= s7_up_r;
    s8_centi_r <= s7_centi_r;
    s8_flag_r  <= s7_flag_r;

    s9_out1_r  <= baro_pkg::fp_add(s8_out1_r, s8_a3_r);
    s9_bsum_r  <= baro_pkg::fp_add(s8_bsum_r, s8_b3_r);
    s9_c4_r    <= baro_pkg::fp_add(s8_c3_r, s8_cube_r);
    s9_up_r    <= s8_up_r;
    s9_centi_r <= s8_centi_r;
    s9_flag_r  <= s8_flag_r;

    s10_out2_r  <= baro_pkg::fp_mul(s9_up_r, s9_bsum_r);
    s10_out1_r  <= s9_out1_r;
    s10_c4_r    <= s9_c4_r;
    s10_centi_r <= s9_centi_r;
    s10_flag_r  <= s9_flag_r;

    s11_press_r <= baro_pkg::fp_add(s10_out1_r, s10_out2_r);
    s11_c4_r    <= s10_c4_r;
    s11_centi_r <= s10_centi_r;
    s11_flag_r  <= s10_flag_r;
  end

  // Output register: final add.
  logic [31:0]        press_r;
  logic signed [15:0] centi_r;
  logic               flag_r;
  always_ff @(posedge clk) begin
    press_r <= baro_pkg::fp_add(s11_press_r, s11_c4_r);
    centi_r <= s11_centi_r;
    flag_r  <= s11_flag_r;
  end

  assign out_valid            = v_r[11];
  assign out_pressure_float   = press_r;
  assign out_temp_centi       = centi_r;
  assign out_reset_value_seen = flag_r;

  `CHK_CLK(a_out_from_ready, out_valid |-> ($past(start, 12) && $past(ready_bits, 12)), "result beat without a ready sample")
  `CHK_CLK(a_flag_source, (out_valid && out_reset_value_seen) |-> (($past(in_raw_pressure, 12) == baro_pkg::RAW_RESET_VALUE) || ($past(in_raw_temperature, 12) == baro_pkg::RAW_RESET_VALUE)), "reset flag without a reset sample")
  `CHK_CLK(a_bad_index, (cfg_we && (cfg_index != baro_pkg::CFG_IDX_LO) && (cfg_index != baro_pkg::CFG_IDX_MID) && (cfg_index != baro_pkg::CFG_IDX_HI)) |=> ($stable(calib_lo_r) && $stable(calib_mid_r) && $stable(calib_hi_r)), "write to unused index changed calibration")

endmodule

// ----- tb/baro_sensor_compensation_checker.sv -----
// Checker for baro_sensor_compensation: watches the calibration, sample and
// reading channels, predicts each reading in bit-exact single precision and
// compares it. Depends on baro_pkg for the status and register constants.
module baro_sensor_compensation_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [7:0]         in_status_byte,
  input  logic [23:0]        in_raw_pressure,
  input  logic [23:0]        in_raw_temperature,
  input  logic               out_valid,
  input  logic signed [15:0] out_temp_centi,
  input  logic [31:0]        out_pressure_float,
  input  logic               out_reset_value_seen,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 readings_pending
);

  localparam logic [31:0] F32_NAN = 32'h7FC00000;

  typedef struct packed {
    logic signed [15:0] temp_centi;
    logic [31:0]        pressure;
    logic               reset_seen;
  } reading_t;

  reading_t     readings_due[$];
  logic [63:0]  calib_lo;
  logic [63:0]  calib_mid;
  logic [39:0]  calib_hi;

  // Rounds sign * m * 2^e to nearest even, with subnormals and overflow.
  function automatic logic [31:0] f32_pack(input logic s, input int e, input logic [79:0] m);
    int          msb;
    int          sh;
    int          be;
    logic [79:0] q;
    logic        g;
    logic        st;
    msb = 0;
    if (m == '0) return {s, 31'b0};
    for (int i = 0; i < 80; i++) if (m[i]) msb = i;
    sh = msb - 23;
    if (sh < -149 - e) sh = -149 - e;
    if (sh > 0) begin
      if (sh > 79) begin
        q = '0;
        g = 1'b0;
        st = 1'b1;
      end else begin
        q = m >> sh;
        g = m[sh-1];
        st = |(m & ((80'b1 << (sh - 1)) - 80'b1));
      end
      q = q + {79'b0, g & (st | q[0])};
    end else begin
      q = m << (-sh);
    end
    if (q[24]) begin
      q = q >> 1;
      sh++;
    end
    be = q[23] ? e + sh + 150 : 0;
    if (be >= 255) return {s, 8'hFF, 23'b0};
    return {s, be[7:0], q[22:0]};
  endfunction

  function automatic logic [31:0] f32_from_int(input int v, input int e);
    return f32_pack(v < 0, e, 80'(v < 0 ? -v : v));
  endfunction

  function automatic int f32_exp(input logic [31:0] a);
    return (a[30:23] == 8'h00 ? 1 : int'(a[30:23])) - 150;
  endfunction

  function automatic logic [23:0] f32_sig(input logic [31:0] a);
    return {a[30:23] != 8'h00, a[22:0]};
  endfunction

  function automatic logic f32_is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != '0;
  endfunction

  function automatic logic f32_is_inf(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == '0;
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (f32_is_nan(a) || f32_is_nan(b)) return F32_NAN;
    if ((f32_is_inf(a) && b[30:0] == '0) || (f32_is_inf(b) && a[30:0] == '0))
      return F32_NAN;
    if (f32_is_inf(a) || f32_is_inf(b)) return {s, 8'hFF, 23'b0};
    return f32_pack(s, f32_exp(a) + f32_exp(b), 80'(f32_sig(a)) * 80'(f32_sig(b)));
  endfunction

  function automatic logic [31:0] f32_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] x;
    logic [31:0] y;
    logic [79:0] ax;
    logic [79:0] by;
    logic [79:0] full;
    logic [79:0] mag;
    logic        s;
    int          d;
    if (f32_is_nan(a) || f32_is_nan(b)) return F32_NAN;
    if (f32_is_inf(a) && f32_is_inf(b) && a[31] != b[31]) return F32_NAN;
    if (f32_is_inf(a)) return a;
    if (f32_is_inf(b)) return b;
    if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'b0};
    if (f32_exp(a) >= f32_exp(b)) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    d = f32_exp(x) - f32_exp(y);
    ax = 80'(f32_sig(x)) << 30;
    full = 80'(f32_sig(y)) << 30;
    if (d >= 80) by = '0;
    else by = full >> d;
    // Bits shifted out of the smaller operand are kept as one sticky bit.
    by[0] = by[0] | (d >= 80 ? full != '0 : (by << d) != full);
    if (x[31] == y[31]) begin
      mag = ax + by;
      s = x[31];
    end else if (ax >= by) begin
      mag = ax - by;
      s = x[31];
    end else begin
      mag = by - ax;
      s = y[31];
    end
    if (mag == '0) return 32'h0;
    return f32_pack(s, f32_exp(x) - 30, mag);
  endfunction

  function automatic logic signed [15:0] f32_to_centi(input logic [31:0] a);
    int          be;
    logic [23:0] whole;
    be = int'(a[30:23]);
    if (f32_is_nan(a)) return 16'sd0;
    if (be >= 150) whole = 24'hFFFFFF;
    else if (150 - be > 24) whole = '0;
    else whole = f32_sig(a) >> (150 - be);
    if (!a[31] && whole >= 24'd32767) return 16'sh7FFF;
    if (a[31] && whole >= 24'd32768) return 16'sh8000;
    return a[31] ? -16'(whole) : 16'(whole);
  endfunction

  function automatic int calib_byte(input int k);
    logic [167:0] all;
    all = {calib_hi, calib_mid, calib_lo};
    return int'(all[8*k +: 8]);
  endfunction

  function automatic int calib_u16(input int k);
    return calib_byte(k) | (calib_byte(k + 1) << 8);
  endfunction

  function automatic int calib_s16(input int k);
    return calib_u16(k) >= 32768 ? calib_u16(k) - 65536 : calib_u16(k);
  endfunction

  function automatic int calib_s8(input int k);
    return calib_byte(k) >= 128 ? calib_byte(k) - 256 : calib_byte(k);
  endfunction

  function automatic reading_t compensate(input logic [23:0] rp, input logic [23:0] rt);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    logic [31:0] d1, sq, tl, tl2, tl3, hi_part, sens, up, quad, cube, press;
    reading_t    r;
    t1  = f32_from_int(calib_u16(0), 8);
    t2  = f32_from_int(calib_u16(2), -30);
    t3  = f32_from_int(calib_s8(4), -48);
    p1  = f32_from_int(calib_s16(5) - 16384, -20);
    p2  = f32_from_int(calib_s16(7) - 16384, -29);
    p3  = f32_from_int(calib_s8(9), -32);
    p4  = f32_from_int(calib_s8(10), -37);
    p5  = f32_from_int(calib_u16(11), 3);
    p6  = f32_from_int(calib_u16(13), -6);
    p7  = f32_from_int(calib_s8(15), -8);
    p8  = f32_from_int(calib_s8(16), -15);
    p9  = f32_from_int(calib_s16(17), -48);
    p10 = f32_from_int(calib_s8(19), -48);
    p11 = f32_from_int(calib_s8(20), -65);

    d1 = f32_add(f32_from_int(int'(rt), 0), {~t1[31], t1[30:0]});
    sq = f32_mul(f32_mul(d1, d1), t3);
    tl = f32_add(f32_mul(d1, t2), sq);
    tl2 = f32_mul(tl, tl);
    tl3 = f32_mul(tl2, tl);

    hi_part = f32_add(p5, f32_mul(p6, tl));
    hi_part = f32_add(hi_part, f32_mul(p7, tl2));
    hi_part = f32_add(hi_part, f32_mul(p8, tl3));

    up = f32_from_int(int'(rp), 0);
    sens = f32_add(p1, f32_mul(p2, tl));
    sens = f32_add(sens, f32_mul(p3, tl2));
    sens = f32_add(sens, f32_mul(p4, tl3));

    quad = f32_mul(f32_mul(up, up), f32_add(p9, f32_mul(p10, tl)));
    cube = f32_mul(f32_mul(f32_mul(up, up), up), p11);
    press = f32_add(hi_part, f32_mul(up, sens));
    press = f32_add(press, f32_add(quad, cube));

    r.temp_centi = f32_to_centi(f32_mul(tl, baro_pkg::FP_HUNDRED));
    r.pressure = press;
    r.reset_seen = (rp == baro_pkg::RAW_RESET_VALUE) || (rt == baro_pkg::RAW_RESET_VALUE);
    return r;
  endfunction

  assign readings_pending = readings_due.size();

  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (!rst_n) begin
      calib_lo <= '0;
      calib_mid <= '0;
      calib_hi <= '0;
      fail_count <= 0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          baro_pkg::CFG_IDX_LO: begin
            calib_lo <= cfg_data;
          end
          baro_pkg::CFG_IDX_MID: begin
            calib_mid <= cfg_data;
          end
          baro_pkg::CFG_IDX_HI: begin
            calib_hi <= cfg_data[39:0];
          end
          default: begin
          end
        endcase
      end
      if (start && !busy && (in_status_byte & baro_pkg::STATUS_PRESS_READY) != 0
          && (in_status_byte & baro_pkg::STATUS_TEMP_READY) != 0)
        readings_due.push_back(compensate(in_raw_pressure, in_raw_temperature));
      if (out_valid) begin
        got = '{out_temp_centi, out_pressure_float, out_reset_value_seen};
        if (readings_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected reading beat: %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = readings_due.pop_front();
          if (got != want) begin
            if (fail_count < 10)
              $display("reading mismatch: expected %p, got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- tb/baro_sensor_compensation_tb.sv -----
// Testbench top for baro_sensor_compensation: drives calibration writes and
// sample beats, directed and in random bursts, and gives the checker's verdict.
// Depends on baro_pkg, the block and baro_sensor_compensation_checker.
module baro_sensor_compensation_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int SAMPLES_PER_PHASE = 320;
  localparam logic [1:0] CFG_IDX_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [7:0]         in_status_byte = '0;
  logic [23:0]        in_raw_pressure = '0;
  logic [23:0]        in_raw_temperature = '0;
  logic               out_valid;
  logic signed [15:0] out_temp_centi;
  logic [31:0]        out_pressure_float;
  logic               out_reset_value_seen;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  int                 fail_count;
  int                 readings_pending;
  int                 quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  baro_sensor_compensation dut (.*);
  baro_sensor_compensation_checker checker_i (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_calib(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_calib(input logic [63:0] lo, input logic [63:0] mid,
                            input logic [63:0] hi);
    write_calib(baro_pkg::CFG_IDX_LO, lo);
    write_calib(baro_pkg::CFG_IDX_MID, mid);
    write_calib(baro_pkg::CFG_IDX_HI, hi);
    // Index 3 is not a register; the write must be ignored.
    write_calib(CFG_IDX_UNUSED, {$urandom, $urandom});
  endtask

  // Holds one sample beat on the inputs until it is taken.
  task automatic send_sample(input logic [7:0] st, input logic [23:0] rp,
                             input logic [23:0] rt);
    logic was_busy;
    @(negedge clk);
    start <= 1'b1;
    in_status_byte <= st;
    in_raw_pressure <= rp;
    in_raw_temperature <= rt;
    forever begin
      was_busy = busy;
      @(posedge clk);
      if (!was_busy) break;
      @(negedge clk);
    end
  endtask

  task automatic pause(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain;
    pause(0);
    while (readings_pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  function automatic logic [23:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return baro_pkg::RAW_RESET_VALUE;
      3, 4, 5: return 24'h600000 + 24'($urandom_range(0, 24'h3FFFFF));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_status();
    logic [7:0] st;
    st = 8'($urandom);
    if ($urandom_range(0, 9) < 8)
      st = st | baro_pkg::STATUS_PRESS_READY | baro_pkg::STATUS_TEMP_READY;
    return st;
  endfunction

  task automatic random_samples(input int count);
    int left;
    int burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 30);
      if (burst > left) burst = left;
      repeat (burst) send_sample(pick_status(), pick_raw(), pick_raw());
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 12));
    end
  endtask

  initial begin
    logic [7:0] ready;
    ready = baro_pkg::STATUS_PRESS_READY | baro_pkg::STATUS_TEMP_READY;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Large t2 so that both temperature extremes saturate.
    load_calib(64'h123456F0FFFF6978, 64'h81C4A3F7007F8000, 64'hFFFFFF807F5A0180);
    send_sample(ready, 24'h000000, 24'h000000);
    send_sample(ready, 24'hFFFFFF, 24'hFFFFFF);
    send_sample(ready, 24'h000000, 24'hFFFFFF);
    send_sample(ready, 24'hFFFFFF, 24'h000000);
    send_sample(ready, baro_pkg::RAW_RESET_VALUE, 24'h697800);
    send_sample(ready, 24'h5A1234, baro_pkg::RAW_RESET_VALUE);
    send_sample(ready, baro_pkg::RAW_RESET_VALUE, baro_pkg::RAW_RESET_VALUE);
    send_sample(ready, 24'h6A0000, 24'h697800);
    send_sample(ready, 24'h6A0000, 24'h697A00);
    send_sample(8'hFF, 24'h123456, 24'h654321);
    send_sample(8'h00, 24'h123456, 24'h654321);
    send_sample(baro_pkg::STATUS_PRESS_READY, 24'h123456, 24'h654321);
    send_sample(baro_pkg::STATUS_TEMP_READY, 24'h123456, 24'h654321);
    send_sample(8'h9F, 24'hFFFFFF, 24'hFFFFFF);
    send_sample(ready | 8'h80, 24'h7FFFFF, 24'h800001);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_calib('0, '0, '0);
        1: load_calib('1, '1, '1);
        default: load_calib({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom});
      endcase
      random_samples(SAMPLES_PER_PHASE);
      drain();
    end

    if (fail_count == 0 && readings_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- baro_sensor_compensation.f -----
+incdir+rtl
rtl/baro_pkg.sv
rtl/baro_sensor_compensation.sv
tb/baro_sensor_compensation_checker.sv
tb/baro_sensor_compensation_tb.sv
